FILE: rtl/lfops_pkg.sv
package lfops_pkg;

  localparam logic CfgSymEnable = 1'b0;
  localparam logic CfgFreqSteps = 1'b1;

  localparam logic        SymEnableReset  = 1'b1;
  localparam logic [10:0] FreqStepsReset  = 11'd600;
  localparam logic [10:0] LowSpanMax      = 11'd115;
  localparam logic [6:0]  ReloadOffset    = 7'd12;
  localparam logic [8:0]  FullPeriod      = 9'd256;
  localparam logic [7:0]  RemHalf         = 8'd128;
  localparam logic [4:0]  IndexMax        = 5'd15;

  typedef struct packed {
    logic       sym_en;
    logic       lengthen;
    logic       odd;
    logic [6:0] offset;
  } ctrl_t;

  typedef struct packed {
    ctrl_t       ctrl;
    logic [14:0] prod;
    logic [6:0]  raw;
    logic [4:0]  base;
    logic [8:0]  period;
  } adj_in_t;

  typedef struct packed {
    logic [8:0] reload;
    logic [3:0] index;
    logic       halved;
    logic [6:0] offset;
  } result_t;

endpackage

FILE: rtl/lfops_adjust.sv
module lfops_adjust (
  input  lfops_pkg::adj_in_t adj_i,
  output lfops_pkg::result_t res_o
);

  logic [6:0] delta;
  logic [7:0] rem;
  logic [8:0] shrt;
  logic [8:0] lng;
  logic       small_span;
  logic       rem_up;
  logic [8:0] shrt_r;
  logic [8:0] lng_r;
  logic [8:0] lng_f;
  logic       alt;
  logic       halved;
  logic       nudge;
  logic [8:0] reload_sym;
  logic [4:0] index_sel;

  always_comb begin
    delta      = adj_i.prod[14:8];
    rem        = adj_i.prod[7:0];
    shrt       = adj_i.period - {2'b00, delta};
    lng        = adj_i.period + {2'b00, delta};
    small_span = !lng[8] || ((lng == lfops_pkg::FullPeriod) && (rem == 8'd0));
    rem_up     = small_span ? (rem > lfops_pkg::RemHalf) : (rem >= lfops_pkg::RemHalf);
    shrt_r     = shrt - {8'd0, rem_up};
    lng_r      = lng + {8'd0, rem_up};
    halved     = !small_span && adj_i.ctrl.lengthen;
    alt        = small_span ? (rem == lfops_pkg::RemHalf) : (adj_i.ctrl.lengthen && lng_r[0]);
    lng_f      = small_span ? lng_r : {1'b0, lng_r[8:1]};
    nudge      = alt && adj_i.ctrl.odd;
    if (adj_i.ctrl.lengthen) begin
      reload_sym = lfops_pkg::FullPeriod - lng_f - {8'd0, nudge};
    end else begin
      reload_sym = lfops_pkg::FullPeriod - shrt_r + {8'd0, nudge};
    end

    if (adj_i.ctrl.sym_en) begin
      index_sel     = halved ? (adj_i.base - 5'd1) : adj_i.base;
      res_o.reload  = reload_sym;
      res_o.halved  = halved;
      res_o.offset  = adj_i.ctrl.offset;
    end else begin
      index_sel     = adj_i.base;
      res_o.reload  = {2'b00, adj_i.raw};
      res_o.halved  = 1'b0;
      res_o.offset  = 7'd0;
    end
    res_o.index = (index_sel > lfops_pkg::IndexMax) ? 4'd15 : index_sel[3:0];
  end

endmodule

FILE: rtl/lfo_period_symmetry_calc.sv
// LFO period and symmetry calculator. Each request on the slave side carries the speed and
// symmetry readings with the waveform position, and yields exactly one result on the master
// side: the timer reload value, the prescaler table index, a halving flag and the symmetry
// amount. The block is a four-stage pipeline (speed multiply, reload and prescaler split,
// period multiply, rounding and symmetry adjust into the output register) and takes one
// request every cycle while the output is not stalled. Each stage holds only while its
// successor is full and stalled, so bubbles close up under back-pressure.
// The two configuration registers are written through the plain write port and should only be
// changed while no request is in flight.
module lfo_period_symmetry_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_tvalid,
  output logic        s_tready,
  // speed_reading[9:0], symmetry_reading[17:10], half_cycle[18], quadrant[19],
  // wave_index[28:20], zero fill[31:29]
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reload_value[8:0], prescaler_index[12:9], prescaler_halved[13],
  // symmetry_offset[20:14], zero fill[23:21]
  output logic [23:0] m_tdata
);

  logic        sym_en_q;
  logic [10:0] freq_steps_q;

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  lfops_pkg::ctrl_t   ctrl1_d, ctrl1_q, ctrl2_q;
  logic [20:0]        scaled_prod_q;
  logic [10:0]        scaled;
  logic [10:0]        sub;
  logic [6:0]         raw_d, raw_q;
  logic [4:0]         base_d, base_q;
  logic [8:0]         period_d, period_q;
  lfops_pkg::adj_in_t adj_q;
  lfops_pkg::result_t res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_en_q     <= lfops_pkg::SymEnableReset;
      freq_steps_q <= lfops_pkg::FreqStepsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfops_pkg::CfgSymEnable: sym_en_q     <= cfg_wdata_i[0];
        lfops_pkg::CfgFreqSteps: freq_steps_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eno      = !vo_q || m_tready;
  assign en3      = !v3_q || eno;
  assign en2      = !v2_q || en3;
  assign en1      = !v1_q || en2;
  assign s_tready = en1;
  assign m_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  always_comb begin
    ctrl1_d.sym_en   = sym_en_q;
    ctrl1_d.lengthen = !s_tdata[17] ^ (s_tdata[18] ^ s_tdata[19]);
    ctrl1_d.odd      = s_tdata[20];
    ctrl1_d.offset   = s_tdata[17] ? s_tdata[16:10] : ~s_tdata[16:10];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      scaled_prod_q <= {11'd0, s_tdata[9:0]} * {10'd0, freq_steps_q};
      ctrl1_q       <= ctrl1_d;
    end
  end

  always_comb begin
    scaled = scaled_prod_q[20:10];
    sub    = scaled - lfops_pkg::LowSpanMax;
    if (scaled <= lfops_pkg::LowSpanMax) begin
      raw_d  = scaled[6:0] + lfops_pkg::ReloadOffset;
      base_d = 5'd1;
    end else begin
      raw_d  = sub[6:0];
      base_d = {1'b0, sub[10:7]} + 5'd2;
    end
    period_d = lfops_pkg::FullPeriod - {2'b00, raw_d};
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      raw_q    <= raw_d;
      base_q   <= base_d;
      period_q <= period_d;
      ctrl2_q  <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      adj_q.prod   <= {6'd0, period_q} * {8'd0, ctrl2_q.offset};
      adj_q.raw    <= raw_q;
      adj_q.base   <= base_q;
      adj_q.period <= period_q;
      adj_q.ctrl   <= ctrl2_q;
    end
  end

  lfops_adjust u_adjust (
    .adj_i (adj_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (eno) begin
      res_q <= res_d;
    end
  end

  assign m_tdata = {3'b000, res_q.offset, res_q.halved, res_q.index, res_q.reload};

  a_stall_only_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a stalled output");

  a_reload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[8:0] <= 9'd256))
    else $error("reload value above full period");

  a_halved_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tdata[13]) |-> ((m_tdata[8:0] >= 9'd63) && (m_tdata[8:0] <= 9'd128)))
    else $error("halved period outside its range");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit   = 1000;
  localparam int SettleCycles = 8;
  localparam int MaxGap       = 6;

  typedef struct packed {
    logic [8:0] wave_index;
    logic       quadrant;
    logic       half_cycle;
    logic [7:0] symmetry_reading;
    logic [9:0] speed_reading;
  } reading_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata     = '0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [23:0] m_tdata;

  bit                  sym_en_q      = lfops_pkg::SymEnableReset;
  int unsigned         freq_steps_q  = 32'(lfops_pkg::FreqStepsReset);
  lfops_pkg::result_t  pending_results[$];
  int                  mismatch_count  = 0;
  int                  quiet_cycles    = 0;
  int                  hold_off_cycles = 0;
  bit                  gaps_on         = 1'b1;

  lfo_period_symmetry_calc i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic lfops_pkg::result_t predict_period(input reading_t rd);
    int unsigned scaled, raw, base, rld, idx, offs, period, prod, delta, rem, shrt, lng;
    bit          cw, lengthen, alt, halved;
    lfops_pkg::result_t res;
    scaled = (rd.speed_reading * freq_steps_q) >> 10;
    if (scaled <= lfops_pkg::LowSpanMax) begin
      raw  = scaled + lfops_pkg::ReloadOffset;
      base = 1;
    end else begin
      raw  = (scaled - lfops_pkg::LowSpanMax) & 127;
      base = ((scaled - lfops_pkg::LowSpanMax) >> 7) + 2;
    end
    rld    = raw;
    idx    = base;
    halved = 1'b0;
    offs   = 0;
    alt    = 1'b0;
    if (sym_en_q) begin
      cw       = rd.symmetry_reading < lfops_pkg::RemHalf;
      lengthen = (rd.half_cycle == rd.quadrant) ? cw : !cw;
      if (cw) offs = 127 - rd.symmetry_reading;
      else    offs = rd.symmetry_reading - lfops_pkg::RemHalf;
      period = lfops_pkg::FullPeriod - raw;
      prod   = period * offs;
      delta  = prod >> 8;
      rem    = prod & 255;
      shrt   = period - delta;
      lng    = period + delta;
      if (lng < lfops_pkg::FullPeriod || (lng == lfops_pkg::FullPeriod && rem == 0)) begin
        if (rem == lfops_pkg::RemHalf) begin
          alt = 1'b1;
        end else if (rem > lfops_pkg::RemHalf) begin
          shrt--;
          lng++;
        end
      end else begin
        if (rem >= lfops_pkg::RemHalf) begin
          shrt--;
          lng++;
        end
        if (lengthen) begin
          alt    = lng[0];
          halved = 1'b1;
        end
        lng = lng >> 1;
      end
      if (lengthen) begin
        rld = lfops_pkg::FullPeriod - lng;
        if (alt && rd.wave_index[0]) rld--;
      end else begin
        rld = lfops_pkg::FullPeriod - shrt;
        if (alt && rd.wave_index[0]) rld++;
      end
      if (halved) idx = base - 1;
    end
    if (idx > lfops_pkg::IndexMax) idx = 32'(lfops_pkg::IndexMax);
    res.reload = rld[8:0];
    res.index  = idx[3:0];
    res.halved = halved;
    res.offset = offs[6:0];
    return res;
  endfunction

  function automatic reading_t make_reading(input int speed, input int symr, input bit hc,
                                            input bit qd, input int widx);
    reading_t rd;
    rd.speed_reading    = speed[9:0];
    rd.symmetry_reading = symr[7:0];
    rd.half_cycle       = hc;
    rd.quadrant         = qd;
    rd.wave_index       = widx[8:0];
    return rd;
  endfunction

  function automatic reading_t random_reading();
    reading_t   rd;
    logic [7:0] sym_edges [4] = '{8'd0, 8'd127, 8'd128, 8'd255};
    rd.speed_reading    = 10'($urandom_range(0, 1023));
    rd.symmetry_reading = 8'($urandom_range(0, 255));
    rd.half_cycle       = 1'($urandom_range(0, 1));
    rd.quadrant         = 1'($urandom_range(0, 1));
    rd.wave_index       = 9'($urandom_range(0, 511));
    if ($urandom_range(0, 7) == 0) rd.symmetry_reading = sym_edges[2'($urandom_range(0, 3))];
    if ($urandom_range(0, 15) == 0) rd.speed_reading = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    return rd;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_reading(input reading_t rd);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, rd};
    do @(posedge clk_i); while (!s_tready);
    pending_results.push_back(predict_period(rd));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [10:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == lfops_pkg::CfgSymEnable) sym_en_q = value[0];
    else                                freq_steps_q = 32'(value);
  endtask

  task automatic test_defaults_directed();
    send_reading(make_reading(0, 0, 1'b0, 1'b0, 0));
    send_reading(make_reading(0, 0, 1'b0, 1'b0, 1));
    send_reading(make_reading(1023, 255, 1'b1, 1'b1, 511));
    send_reading(make_reading(89, 125, 1'b0, 1'b0, 0));
    send_reading(make_reading(89, 125, 1'b0, 1'b0, 1));
    send_reading(make_reading(89, 130, 1'b0, 1'b1, 1));
    send_reading(make_reading(89, 125, 1'b0, 1'b1, 1));
    send_reading(make_reading(89, 125, 1'b1, 1'b0, 0));
    send_reading(make_reading(415, 127, 1'b0, 1'b0, 3));
    send_reading(make_reading(415, 128, 1'b1, 1'b0, 2));
    send_reading(make_reading(197, 0, 1'b1, 1'b1, 5));
    send_reading(make_reading(198, 255, 1'b0, 1'b1, 6));
    send_reading(make_reading(1023, 0, 1'b0, 1'b0, 511));
    wait_drained();
  endtask

  task automatic test_symmetry_bypass();
    write_register(lfops_pkg::CfgSymEnable, 11'd0);
    send_reading(make_reading(1023, 0, 1'b0, 1'b0, 511));
    send_reading(make_reading(0, 255, 1'b1, 1'b0, 0));
    send_reading(make_reading(89, 125, 1'b0, 1'b0, 1));
    send_reading(make_reading(415, 128, 1'b1, 1'b1, 2));
    wait_drained();
    write_register(lfops_pkg::CfgSymEnable, 11'd1);
  endtask

  task automatic test_frequency_extremes();
    write_register(lfops_pkg::CfgFreqSteps, 11'd2047);
    send_reading(make_reading(1023, 0, 1'b0, 1'b0, 1));
    send_reading(make_reading(1023, 255, 1'b0, 1'b0, 0));
    send_reading(make_reading(512, 64, 1'b1, 1'b0, 7));
    wait_drained();
    write_register(lfops_pkg::CfgFreqSteps, 11'd0);
    send_reading(make_reading(1023, 200, 1'b1, 1'b0, 9));
    send_reading(make_reading(0, 127, 1'b0, 1'b1, 8));
    wait_drained();
    write_register(lfops_pkg::CfgFreqSteps, 11'd1);
    send_reading(make_reading(1023, 10, 1'b1, 1'b1, 255));
    wait_drained();
    write_register(lfops_pkg::CfgFreqSteps, lfops_pkg::FreqStepsReset);
  endtask

  task automatic test_input_backpressure();
    gaps_on         = 1'b0;
    hold_off_cycles = 150;
    for (int n = 0; n < 40; n++) send_reading(random_reading());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_settings();
    bit          sym_plan  [7] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    int unsigned freq_plan [7] = '{600, 1024, 1, 1024, 0, 2047, 300};
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_register(lfops_pkg::CfgSymEnable, {10'd0, sym_plan[p]});
      if (p == 6) write_register(lfops_pkg::CfgFreqSteps, 11'($urandom_range(2, 1023)));
      else        write_register(lfops_pkg::CfgFreqSteps, 11'(freq_plan[p]));
      gaps_on = (p % 3) != 1;
      for (int n = 0; n < 125; n++) send_reading(random_reading());
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // The receiver may stall before each result while gaps are on; a requested hold-off is counted here.
  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  always @(posedge clk_i) begin
    lfops_pkg::result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%06h with no request outstanding", m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[8:0] !== want.reload)
          report_mismatch($sformatf("reload_value got %0d expected %0d",
                                    m_tdata[8:0], want.reload));
        if (m_tdata[12:9] !== want.index)
          report_mismatch($sformatf("prescaler_index got %0d expected %0d",
                                    m_tdata[12:9], want.index));
        if (m_tdata[13] !== want.halved)
          report_mismatch($sformatf("prescaler_halved got %0d expected %0d",
                                    m_tdata[13], want.halved));
        if (m_tdata[20:14] !== want.offset)
          report_mismatch($sformatf("symmetry_offset got %0d expected %0d",
                                    m_tdata[20:14], want.offset));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_directed();
    test_symmetry_bypass();
    test_frequency_extremes();
    test_input_backpressure();
    test_random_settings();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
